// ===== rtl/ragmt_pkg.sv =====
`timescale 1ns / 1ps
package ragmt_pkg;

	typedef struct packed {
		logic [63:0] mx;
		logic [63:0] pend;
	} node_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ROOT_RD,
		ST_ROOT_WR,
		ST_DN_V,
		ST_DN_P,
		ST_DN_L,
		ST_DN_R,
		ST_UP_L,
		ST_UP_R,
		ST_UP_W,
		ST_OUT_RD,
		ST_OUT_CAP
	} state_t;

endpackage

// ===== rtl/range_add_global_max_tree_core.sv =====
`timescale 1ns / 1ps
// channel | dir | tdata fields (low bit up)                           | note
// s_      | in  | range_low[9:0], range_high[19:10], delta[51:20], pad | one update
// m_      | out | global_max[63:0]                                     | one per update
// An update walks the two boundary paths of the tree: down, pushing pending adds
// (ST_DN_V, ST_DN_P, ST_DN_L, ST_DN_R for each partly covered node), then up recomputing
// maxima (ST_UP_L, ST_UP_R, ST_UP_W per node), plus the accept and the root read (ST_IDLE,
// ST_OUT_RD, ST_OUT_CAP). All steps share one node memory port pair. At most
// 2*log2(LEAVES)-1 nodes are partly covered; an empty range leaves the tree as it is, and
// a whole-array range only updates the root (ST_ROOT_RD, ST_ROOT_WR). After reset a clearing
// pass zeroes all 2*2^clog2(LEAVES) memory words; no word is taken meanwhile. A stalled result
// waits in the output register; the next update holds in its last step until that register drains.
module range_add_global_max_tree_core #(
	parameter int LEAVES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // range_low, range_high, delta, zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // global_max
);

	localparam int LW = (LEAVES > 1) ? $clog2(LEAVES) : 1;
	localparam int NW = LW + 1;
	localparam int MEMD = 1 << NW;
	localparam int DEPTH = LW + 1;
	localparam int LVW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = ((LW > 10) ? LW : 10) + 1;
	localparam logic [CW-1:0] LAST_C = CW'(LEAVES - 1);

	ragmt_pkg::state_t state_q, state_d;

	ragmt_pkg::node_t mem [MEMD];
	ragmt_pkg::node_t rdata_q, wdata;
	logic [NW-1:0] raddr, waddr;
	logic we;

	logic [NW-1:0] clr_q;
	logic [LW-1:0] lo_q, hi_q;
	logic [63:0] d_q, p_q, lmax_q, out_q;
	logic ovalid_q;
	logic [LVW-1:0] lvl_q;
	logic sl_q;
	logic [1:0] nc_q;
	logic [NW-1:0] node_q [DEPTH][2];
	logic [LW-1:0] a_q [DEPTH][2];
	logic [LW-1:0] b_q [DEPTH][2];
	logic [1:0] cnt_q [DEPTH];

	// input decode
	logic [CW-1:0] lo_e, hi_e, hi_c;
	logic empty, full;
	assign lo_e = CW'(s_tdata[9:0]);
	assign hi_e = CW'(s_tdata[19:10]);
	assign hi_c = (hi_e > LAST_C) ? LAST_C : hi_e;
	assign empty = lo_e > hi_c;
	assign full = (lo_e == '0) && (hi_c == LAST_C);

	// current node and its children
	logic [NW-1:0] cur_v, lch, rch;
	logic [LW-1:0] cur_a, cur_b, mid, mid1;
	logic cov_l, part_l, cov_r, part_r, more_slot;
	logic [LVW-1:0] lvl_n;
	logic [1:0] nc_end;
	logic [63:0] add_l, add_r, upd_add;

	assign cur_v = node_q[lvl_q][sl_q];
	assign cur_a = a_q[lvl_q][sl_q];
	assign cur_b = b_q[lvl_q][sl_q];
	assign lch = {cur_v[NW-2:0], 1'b0};
	assign rch = {cur_v[NW-2:0], 1'b1};
	assign mid = cur_a + ((cur_b - cur_a) >> 1);
	assign mid1 = mid + 1'b1;
	assign cov_l = (lo_q <= cur_a) && (mid <= hi_q);
	assign part_l = !cov_l && !((mid < lo_q) || (hi_q < cur_a));
	assign cov_r = (lo_q <= mid1) && (cur_b <= hi_q);
	assign part_r = !cov_r && !((cur_b < lo_q) || (hi_q < mid1));
	assign add_l = p_q + (cov_l ? d_q : 64'd0);
	assign add_r = p_q + (cov_r ? d_q : 64'd0);
	assign more_slot = (sl_q == 1'b0) && (cnt_q[lvl_q] == 2'd2);
	assign lvl_n = lvl_q + 1'b1;
	assign nc_end = nc_q + {1'b0, part_r};
	assign upd_add = rdata_q.mx;

	assign s_tready = (state_q == ragmt_pkg::ST_IDLE);
	assign m_tvalid = ovalid_q;
	assign m_tdata = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ragmt_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		raddr = '0;
		we = 1'b0;
		waddr = '0;
		wdata = '0;
		case (state_q)
			ragmt_pkg::ST_CLEAR: begin
				we = 1'b1;
				waddr = clr_q;
				if (clr_q == NW'(MEMD - 1)) begin
					state_d = ragmt_pkg::ST_IDLE;
				end
			end
			ragmt_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (empty) begin
						state_d = ragmt_pkg::ST_OUT_RD;
					end else if (full) begin
						state_d = ragmt_pkg::ST_ROOT_RD;
					end else begin
						state_d = ragmt_pkg::ST_DN_V;
					end
				end
			end
			ragmt_pkg::ST_ROOT_RD: begin
				raddr = NW'(1);
				state_d = ragmt_pkg::ST_ROOT_WR;
			end
			ragmt_pkg::ST_ROOT_WR: begin
				we = 1'b1;
				waddr = NW'(1);
				wdata.mx = rdata_q.mx + d_q;
				wdata.pend = rdata_q.pend + d_q;
				state_d = ragmt_pkg::ST_OUT_RD;
			end
			ragmt_pkg::ST_DN_V: begin
				raddr = cur_v;
				state_d = ragmt_pkg::ST_DN_P;
			end
			ragmt_pkg::ST_DN_P: begin
				// pending moves to the children
				we = 1'b1;
				waddr = cur_v;
				wdata.mx = rdata_q.mx;
				wdata.pend = '0;
				raddr = lch;
				state_d = ragmt_pkg::ST_DN_L;
			end
			ragmt_pkg::ST_DN_L: begin
				we = 1'b1;
				waddr = lch;
				wdata.mx = rdata_q.mx + add_l;
				wdata.pend = rdata_q.pend + add_l;
				raddr = rch;
				state_d = ragmt_pkg::ST_DN_R;
			end
			ragmt_pkg::ST_DN_R: begin
				we = 1'b1;
				waddr = rch;
				wdata.mx = rdata_q.mx + add_r;
				wdata.pend = rdata_q.pend + add_r;
				if (more_slot || nc_end != 2'd0) begin
					state_d = ragmt_pkg::ST_DN_V;
				end else begin
					state_d = ragmt_pkg::ST_UP_L;
				end
			end
			ragmt_pkg::ST_UP_L: begin
				raddr = lch;
				state_d = ragmt_pkg::ST_UP_R;
			end
			ragmt_pkg::ST_UP_R: begin
				raddr = rch;
				state_d = ragmt_pkg::ST_UP_W;
			end
			ragmt_pkg::ST_UP_W: begin
				we = 1'b1;
				waddr = cur_v;
				wdata.mx = ($signed(upd_add) > $signed(lmax_q)) ? upd_add : lmax_q;
				wdata.pend = '0;
				if (more_slot || lvl_q != '0) begin
					state_d = ragmt_pkg::ST_UP_L;
				end else begin
					state_d = ragmt_pkg::ST_OUT_RD;
				end
			end
			ragmt_pkg::ST_OUT_RD: begin
				raddr = NW'(1);
				state_d = ragmt_pkg::ST_OUT_CAP;
			end
			ragmt_pkg::ST_OUT_CAP: begin
				raddr = NW'(1);
				if (!ovalid_q || m_tready) begin
					state_d = ragmt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ragmt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			ovalid_q <= 1'b0;
			lvl_q <= '0;
			sl_q <= 1'b0;
			nc_q <= '0;
		end else begin
			if (state_q == ragmt_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ragmt_pkg::ST_OUT_CAP && (!ovalid_q || m_tready)) begin
				ovalid_q <= 1'b1;
			end else if (ovalid_q && m_tready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ragmt_pkg::ST_IDLE: begin
					lvl_q <= '0;
					sl_q <= 1'b0;
					nc_q <= '0;
				end
				ragmt_pkg::ST_DN_L: begin
					nc_q <= nc_q + {1'b0, part_l};
				end
				ragmt_pkg::ST_DN_R: begin
					if (more_slot) begin
						sl_q <= 1'b1;
						nc_q <= nc_end;
					end else if (nc_end != 2'd0) begin
						lvl_q <= lvl_n;
						sl_q <= 1'b0;
						nc_q <= '0;
					end else begin
						sl_q <= 1'b0;
					end
				end
				ragmt_pkg::ST_UP_W: begin
					if (more_slot) begin
						sl_q <= 1'b1;
					end else if (lvl_q != '0) begin
						lvl_q <= lvl_q - 1'b1;
						sl_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ragmt_pkg::ST_IDLE: begin
				lo_q <= lo_e[LW-1:0];
				hi_q <= hi_c[LW-1:0];
				d_q <= {{32{s_tdata[51]}}, s_tdata[51:20]};
				node_q[0][0] <= NW'(1);
				a_q[0][0] <= '0;
				b_q[0][0] <= LAST_C[LW-1:0];
				cnt_q[0] <= 2'd1;
			end
			ragmt_pkg::ST_DN_P: begin
				p_q <= rdata_q.pend;
			end
			ragmt_pkg::ST_DN_L: begin
				if (part_l) begin
					node_q[lvl_n][nc_q[0]] <= lch;
					a_q[lvl_n][nc_q[0]] <= cur_a;
					b_q[lvl_n][nc_q[0]] <= mid;
				end
			end
			ragmt_pkg::ST_DN_R: begin
				if (part_r) begin
					node_q[lvl_n][nc_q[0]] <= rch;
					a_q[lvl_n][nc_q[0]] <= mid1;
					b_q[lvl_n][nc_q[0]] <= cur_b;
				end
				if (!more_slot) begin
					cnt_q[lvl_n] <= nc_end;
				end
			end
			ragmt_pkg::ST_UP_R: begin
				lmax_q <= rdata_q.mx;
			end
			ragmt_pkg::ST_OUT_CAP: begin
				if (!ovalid_q || m_tready) begin
					out_q <= rdata_q.mx;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
